// ===== hdl/wxo_pkg.sv =====
// shared types and constants for the wavetable x-y oscillator
package wxo_pkg;

    // request kinds carried on tuser
    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // configuration register indexes
    localparam logic [1:0] REG_PHASE_INC = 2'd0;
    localparam logic [1:0] REG_X_POS     = 2'd1;
    localparam logic [1:0] REG_Y_POS     = 2'd2;

    // sample width in signed 1.16 after scaling a table word by two
    localparam int SAMPLE_W = 17;
    localparam int WORD_W   = 16;
    localparam int FRAC_W   = 16;

    // half an lsb of the 16-bit fraction, for round to nearest
    localparam int HALF_LSB = 1 << 15;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    // destination of a blend result
    typedef enum logic [2:0] {
        TAG_W0,
        TAG_W1,
        TAG_W2,
        TAG_W3,
        TAG_X0,
        TAG_X1,
        TAG_Y
    } t_tag;

    typedef struct packed {
        logic              valid;
        t_tag              tag;
        logic [FRAC_W-1:0] mu;
        t_sample           a;
        t_sample           b;
    } t_blend_req;

    typedef struct packed {
        logic    valid;
        t_tag    tag;
        t_sample value;
    } t_blend_rsp;

endpackage

// ===== hdl/wxo_wave_mem.sv =====
// wave table memory, one write port and one registered read port
module wxo_wave_mem #(
    parameter int DEPTH  = 16384,
    parameter int ADDR_W = 14
) (
    input  logic                               i_clk,
    input  logic                               i_we,
    input  logic [ADDR_W-1:0]                  i_waddr,
    input  logic signed [wxo_pkg::WORD_W-1:0]  i_wdata,
    input  logic                               i_re,
    input  logic [ADDR_W-1:0]                  i_raddr,
    output logic signed [wxo_pkg::WORD_W-1:0]  o_rdata
);

    logic signed [wxo_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic signed [wxo_pkg::WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/wxo_blend.sv =====
// shared two-stage blend unit: a + round(mu * (b - a) / 2^16)
module wxo_blend (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wxo_pkg::t_blend_req i_req,
    output wxo_pkg::t_blend_rsp o_rsp
);

    logic signed [wxo_pkg::SAMPLE_W:0]   w_diff;
    logic signed [wxo_pkg::SAMPLE_W-1:0] w_mu_s;
    logic signed [34:0]                  w_prod;
    logic signed [34:0]                  w_bias;
    logic signed [34:0]                  w_round;
    logic signed [34:0]                  w_step;

    logic signed [34:0]  r_prod;
    wxo_pkg::t_sample    r_a;
    wxo_pkg::t_tag       r_tag;
    logic                r_valid;
    logic                r_rsp_valid;
    wxo_pkg::t_tag       r_rsp_tag;
    wxo_pkg::t_sample    r_rsp_value;

    // stage 1: difference and product
    always_comb begin
        w_diff = $signed({i_req.b[wxo_pkg::SAMPLE_W-1], i_req.b})
               - $signed({i_req.a[wxo_pkg::SAMPLE_W-1], i_req.a});
        w_mu_s = $signed({1'b0, i_req.mu});
        w_prod = 35'(w_mu_s) * 35'(w_diff);
    end

    // stage 2: round half away from zero, then add the base
    always_comb begin
        w_bias  = r_prod[34] ? 35'(wxo_pkg::HALF_LSB - 1) : 35'(wxo_pkg::HALF_LSB);
        w_round = r_prod + w_bias;
        w_step  = w_round >>> wxo_pkg::FRAC_W;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_valid     <= i_req.valid;
            r_rsp_valid <= r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod      <= w_prod;
        r_a         <= i_req.a;
        r_tag       <= i_req.tag;
        r_rsp_tag   <= r_tag;
        r_rsp_value <= wxo_pkg::t_sample'(r_a + w_step[wxo_pkg::SAMPLE_W-1:0]);
    end

    assign o_rsp = '{valid: r_rsp_valid, tag: r_rsp_tag, value: r_rsp_value};

endmodule

// ===== hdl/wavetable_xy_oscillator.sv =====
// top level of the bilinear wavetable oscillator with phase accumulator
//
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+-------------------------------------
// s_axis    | in        | tvalid / tready        | tuser: req_type; tdata: address, data
// m_axis    | out       | tvalid / tready        | tdata: sample_out (signed 1.16)
// apb       | in        | psel, penable, pwrite  | paddr, pwdata, prdata; pready tied high
//
// a table write item is written to the wave memory at the accept edge
// a tick item makes eight reads from the single read port of the wave memory and seven
//   blends through one shared two-stage multiplier
// the output register holds one sample; a finished tick waits in the done state while it
//   is full and m_axis_tready is low, and items are taken only in idle
// reset clears the phase accumulator, the configuration registers and the control; the wave
//   memory is not cleared, and the user must write every entry before it is read (not enforced)
module wavetable_xy_oscillator #(
    parameter int SAMPLES_PER_WAVE = 256,
    parameter int GRID_COLUMNS     = 8,
    parameter int GRID_ROWS        = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [13:0] table_address, [29:14] table_data, pad
    input  logic        s_axis_tuser,   // [0] req_type
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] sample_out, pad
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CW        = $clog2(GRID_COLUMNS);
    localparam int RW        = $clog2(GRID_ROWS);
    localparam int SW        = $clog2(SAMPLES_PER_WAVE);
    localparam int PW        = wxo_pkg::FRAC_W + SW;
    localparam int MEM_WORDS = GRID_ROWS * GRID_COLUMNS * SAMPLES_PER_WAVE;
    localparam int AW        = $clog2(MEM_WORDS);

    localparam logic [19:0] X_TOP = 20'((GRID_COLUMNS - 1) * 65536);
    localparam logic [19:0] Y_TOP = 20'((GRID_ROWS - 1) * 65536);

    // step schedule of one tick
    localparam logic [4:0] STEP_READS = 5'd8;
    localparam logic [4:0] STEP_LAST  = 5'd16;

    // configuration registers
    logic [15:0] r_phase_inc;
    logic [18:0] r_x_pos;
    logic [18:0] r_y_pos;
    logic        w_cfg_wr;

    // control
    wxo_pkg::t_state r_state;
    wxo_pkg::t_state n_state;
    logic [4:0]      r_cnt;
    logic [15:0]     r_phase;
    logic            w_in_ready;
    logic            w_in_accept;
    logic            w_tick;
    logic            w_read_en;
    logic            w_out_load;

    // input fields
    logic [13:0]        w_table_address;
    logic signed [15:0] w_table_data;
    logic               w_mem_we;

    // grid position split
    logic [19:0]   w_x_sat;
    logic [19:0]   w_y_sat;
    logic [CW-1:0] w_ax;
    logic [CW-1:0] w_bx;
    logic [RW-1:0] w_ay;
    logic [RW-1:0] w_by;
    logic [15:0]   w_mx;
    logic [15:0]   w_my;

    // phase split
    logic [PW-1:0] w_pos;
    logic [SW-1:0] w_ia;
    logic [SW-1:0] w_ib;
    logic [15:0]   w_mu;

    // memory read side
    logic [RW-1:0]      w_row;
    logic [CW-1:0]      w_col;
    logic [SW-1:0]      w_idx;
    logic [AW-1:0]      w_raddr;
    logic signed [15:0] w_rdata;
    wxo_pkg::t_sample   w_rd_word;
    wxo_pkg::t_sample   r_even;

    // blend unit and partial results
    wxo_pkg::t_blend_req w_req;
    wxo_pkg::t_blend_rsp w_rsp;
    wxo_pkg::t_sample    r_val [7];

    // output register
    logic             r_out_valid;
    wxo_pkg::t_sample r_out;

    // ---------------------------------------------------------------- config port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_x_pos     <= '0;
            r_y_pos     <= '0;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                wxo_pkg::REG_PHASE_INC: r_phase_inc <= pwdata[15:0];
                wxo_pkg::REG_X_POS:     r_x_pos     <= pwdata[18:0];
                wxo_pkg::REG_Y_POS:     r_y_pos     <= pwdata[18:0];
                default:                ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            wxo_pkg::REG_PHASE_INC: prdata = {16'd0, r_phase_inc};
            wxo_pkg::REG_X_POS:     prdata = {13'd0, r_x_pos};
            wxo_pkg::REG_Y_POS:     prdata = {13'd0, r_y_pos};
            default:                prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- input side
    assign w_table_address = s_axis_tdata[13:0];
    assign w_table_data    = $signed(s_axis_tdata[29:14]);
    assign w_in_accept     = s_axis_tvalid && w_in_ready;
    assign w_tick          = w_in_accept && (s_axis_tuser == wxo_pkg::REQ_TICK);
    // writes past the end of the memory are dropped
    assign w_mem_we        = w_in_accept && (s_axis_tuser == wxo_pkg::REQ_WRITE)
                           && (32'(w_table_address) < 32'(MEM_WORDS));
    assign s_axis_tready   = w_in_ready;

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wxo_pkg::ST_IDLE: if (w_tick) n_state = wxo_pkg::ST_RUN;
            wxo_pkg::ST_RUN:  if (r_cnt == STEP_LAST) n_state = wxo_pkg::ST_DONE;
            wxo_pkg::ST_DONE: if (w_out_load) n_state = wxo_pkg::ST_IDLE;
            default:          n_state = wxo_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_read_en  = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            wxo_pkg::ST_IDLE: w_in_ready = 1'b1;
            wxo_pkg::ST_RUN:  w_read_en  = (r_cnt < STEP_READS);
            wxo_pkg::ST_DONE: w_out_load = !r_out_valid || m_axis_tready;
            default:          ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wxo_pkg::ST_IDLE;
            r_cnt   <= '0;
            r_phase <= '0;
        end else begin
            r_state <= n_state;
            if (w_tick) begin
                r_cnt <= '0;
            end else if (r_state == wxo_pkg::ST_RUN) begin
                r_cnt <= r_cnt + 5'd1;
            end
            // phase advances once the sample has left for the output register
            if (w_out_load) begin
                r_phase <= r_phase + r_phase_inc;
            end
        end
    end

    // ---------------------------------------------------------------- grid and phase split
    // positions above the last column or row clamp to it
    always_comb begin
        w_x_sat = ({1'b0, r_x_pos} > X_TOP) ? X_TOP : {1'b0, r_x_pos};
        w_y_sat = ({1'b0, r_y_pos} > Y_TOP) ? Y_TOP : {1'b0, r_y_pos};
        w_ax    = w_x_sat[wxo_pkg::FRAC_W +: CW];
        w_ay    = w_y_sat[wxo_pkg::FRAC_W +: RW];
        w_mx    = w_x_sat[15:0];
        w_my    = w_y_sat[15:0];
        w_bx    = (w_mx != 16'd0) ? w_ax + CW'(1) : w_ax;
        w_by    = (w_my != 16'd0) ? w_ay + RW'(1) : w_ay;
    end

    always_comb begin
        w_pos = PW'(r_phase) * PW'(SAMPLES_PER_WAVE);
        w_ia  = w_pos[PW-1:wxo_pkg::FRAC_W];
        w_mu  = w_pos[15:0];
        // the sample after the last one wraps to the start of the same wave
        if (w_mu == 16'd0) begin
            w_ib = w_ia;
        end else if (w_ia == SW'(SAMPLES_PER_WAVE - 1)) begin
            w_ib = '0;
        end else begin
            w_ib = w_ia + SW'(1);
        end
    end

    // ---------------------------------------------------------------- memory reads
    // step k reads wave k[2:1] (row bit, column bit), sample k[0] (first, second)
    always_comb begin
        w_row   = r_cnt[2] ? w_by : w_ay;
        w_col   = r_cnt[1] ? w_bx : w_ax;
        w_idx   = r_cnt[0] ? w_ib : w_ia;
        w_raddr = AW'((AW'(w_row) * AW'(GRID_COLUMNS) + AW'(w_col)) * AW'(SAMPLES_PER_WAVE))
                + AW'(w_idx);
    end

    wxo_wave_mem #(
        .DEPTH  (MEM_WORDS),
        .ADDR_W (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (AW'(w_table_address)),
        .i_wdata (w_table_data),
        .i_re    (w_read_en),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // a table word v stands for 2*v in signed 1.16
    assign w_rd_word = $signed({w_rdata, 1'b0});

    // first sample of each pair arrives on odd steps
    always_ff @(posedge i_clk) begin
        if (r_cnt[0]) begin
            r_even <= w_rd_word;
        end
    end

    // ---------------------------------------------------------------- blend schedule
    // waves blend as their second sample lands, each x pair once both its waves are in, then y
    always_comb begin
        w_req.valid = 1'b0;
        w_req.tag   = wxo_pkg::TAG_W0;
        w_req.mu    = w_mu;
        w_req.a     = r_even;
        w_req.b     = w_rd_word;
        if (r_state == wxo_pkg::ST_RUN) begin
            unique case (r_cnt)
                5'd2: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_W0;
                end
                5'd4: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_W1;
                end
                5'd6: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_W2;
                end
                5'd7: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_X0;
                    w_req.mu    = w_mx;
                    w_req.a     = r_val[wxo_pkg::TAG_W0];
                    w_req.b     = r_val[wxo_pkg::TAG_W1];
                end
                5'd8: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_W3;
                end
                5'd11: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_X1;
                    w_req.mu    = w_mx;
                    w_req.a     = r_val[wxo_pkg::TAG_W2];
                    w_req.b     = r_val[wxo_pkg::TAG_W3];
                end
                5'd14: begin
                    w_req.valid = 1'b1;
                    w_req.tag   = wxo_pkg::TAG_Y;
                    w_req.mu    = w_my;
                    w_req.a     = r_val[wxo_pkg::TAG_X0];
                    w_req.b     = r_val[wxo_pkg::TAG_X1];
                end
                default: ;
            endcase
        end
    end

    wxo_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (w_rsp.valid) begin
            r_val[w_rsp.tag] <= w_rsp.value;
        end
    end

    // ---------------------------------------------------------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= r_val[wxo_pkg::TAG_Y];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out};

    // ---------------------------------------------------------------- checks
    // the final blend lands exactly on the last step of a tick
    a_final_on_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_rsp.valid && (w_rsp.tag == wxo_pkg::TAG_Y))
            |-> ((r_state == wxo_pkg::ST_RUN) && (r_cnt == STEP_LAST)))
        else $error("final blend outside the last step");

    // no blend result arrives while idle
    a_no_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wxo_pkg::ST_IDLE) |-> !w_rsp.valid)
        else $error("blend result while idle");

    // phase moves only with a sample handed to the output register
    a_phase_with_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> $past(w_out_load))
        else $error("phase changed without an output sample");

    // a new output item comes only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state == wxo_pkg::ST_DONE))
        else $error("output valid without a finished tick");

endmodule
